### hw/rtl/svd_pkg.sv
// ----------------------------------------------------------------------------
// Stereo vibrato delay package
// Shared constants, configuration register indexes and the quarter-wave sine
// table that drives the delay modulation.
// ----------------------------------------------------------------------------
`default_nettype none

package svd_pkg;

   localparam int RING_DEPTH_DEFAULT  = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int DEPTH_W      = 9;
   localparam int STEP_W       = 20;
   localparam int PHASE_W      = 24;
   localparam int SCALE_W      = 17;
   localparam int PRODUCT_W    = DEPTH_W + SCALE_W;
   localparam int OFFSET_W     = PRODUCT_W - 15;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = STEP_W;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 9'd48;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd3495;
   localparam logic [SCALE_W-1:0] SCALE_ZERO  = 17'd32768;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEPTH      = 2'd0,
      CSR_PHASE_STEP = 2'd1
   } csr_index_type;

   localparam logic [15:0] QUARTER_SINE [33] = '{
      16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
      16'd9512,  16'd11039, 16'd12539, 16'd14010, 16'd15446, 16'd16846,
      16'd18204, 16'd19519, 16'd20787, 16'd22005, 16'd23170, 16'd24279,
      16'd25329, 16'd26319, 16'd27245, 16'd28105, 16'd28898, 16'd29621,
      16'd30273, 16'd30852, 16'd31356, 16'd31785, 16'd32137, 16'd32412,
      16'd32609, 16'd32728, 16'd32767
   };

   // Returns 32768 plus the sine of the phase, which lies in 1 to 65535.
   function automatic logic [SCALE_W-1:0] lfo_scale(input logic [PHASE_W-1:0] phase);
      logic [1:0]         quad;
      logic [5:0]         idx;
      logic [15:0]        mag;
      logic [SCALE_W-1:0] result;
      quad = phase[23:22];
      idx  = {1'b0, phase[21:17]};
      if (quad[0]) begin
         mag = QUARTER_SINE[6'd32 - idx];
      end else begin
         mag = QUARTER_SINE[idx];
      end
      if (quad[1]) begin
         result = SCALE_ZERO - {1'b0, mag};
      end else begin
         result = SCALE_ZERO + {1'b0, mag};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/svd_ring.sv
// ----------------------------------------------------------------------------
// Stereo vibrato delay ring buffer
// One channel's delay ring: a simple dual-port memory with one write port and
// one read port whose data is registered, read only when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module svd_ring #(
   parameter int RING_DEPTH  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  wire logic [SAMPLE_BITS-1:0]        wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output logic      [SAMPLE_BITS-1:0]        rd_data
);

   logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/stereo_vibrato_delay_top.sv
// ----------------------------------------------------------------------------
// Stereo vibrato delay
// A modulated delay line over two ring buffers, one stereo pair per beat.
//
// The req channel takes a stereo pair and the rsp channel returns the delayed
// pair, halved. Each accepted beat writes both samples at the write pointer and
// reads both rings at the read pointer formed on the previous beat. The read
// data is registered inside the ring memories and then moves into the rsp
// output register. One beat is accepted per clock while req_ready is high; the
// single-port-per-direction ring memories and the depth-times-sine multiply
// set that figure. The next read pointer is formed in the accept cycle from a
// sine scale that is prepared one beat early. When rsp stalls, one further
// beat waits in the memory read stage and req_ready drops only once both
// stages are full. Reset clears the pointers, the fill count, the phase and
// the valid flags and loads the scale, depth and step defaults. Ring entries
// that were never written read as zero through a fill count, so no clearing
// pass is needed. The csr port writes depth_samples (index 0) and phase_step
// (index 1) at once; it is meant to be used only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_vibrato_delay_top #(
   parameter int RING_DEPTH  = svd_pkg::RING_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = svd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_right_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed      [SAMPLE_BITS-2:0]       rsp_left_out,
   output logic signed      [SAMPLE_BITS-2:0]       rsp_right_out,
   input  wire logic                                csr_we,
   input  wire logic        [svd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [svd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import svd_pkg::*;

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int WIDE_W = PTR_W + OFFSET_W;

   logic [PTR_W-1:0]       wp_ff, wp_in;
   logic [PTR_W-1:0]       rp_ff, rp_in;
   logic [PTR_W:0]         fill_ff, fill_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [SCALE_W-1:0]     scale_ff, scale_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_hit_ff, s1_hit_in;
   logic                   s1_fwd_ff, s1_fwd_in;
   logic [SAMPLE_BITS-1:0] s1_left_ff, s1_left_in;
   logic [SAMPLE_BITS-1:0] s1_right_ff, s1_right_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-2:0] rsp_left_ff, rsp_left_in;
   logic [SAMPLE_BITS-2:0] rsp_right_ff, rsp_right_in;

   logic                   accept;
   logic                   s1_move;
   logic [PRODUCT_W-1:0]   product;
   logic [OFFSET_W-1:0]    offset;
   logic [WIDE_W-1:0]      rp_wide;
   logic [PHASE_W-1:0]     phase_next;
   logic [SAMPLE_BITS-1:0] ring_left, ring_right;
   logic [SAMPLE_BITS-1:0] sel_left, sel_right;

   assign accept    = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;

   svd_ring #(
      .RING_DEPTH (RING_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_left_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(wp_ff),
      .wr_data(req_left_in),
      .rd_en  (accept),
      .rd_addr(rp_ff),
      .rd_data(ring_left)
   );

   svd_ring #(
      .RING_DEPTH (RING_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_right_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(wp_ff),
      .wr_data(req_right_in),
      .rd_en  (accept),
      .rd_addr(rp_ff),
      .rd_data(ring_right)
   );

   always_comb begin
      product    = PRODUCT_W'(depth_ff) * PRODUCT_W'(scale_ff);
      offset     = product[PRODUCT_W-1:15];
      rp_wide    = WIDE_W'(wp_ff) - WIDE_W'(offset);
      phase_next = phase_ff + PHASE_W'(step_ff);

      wp_in    = wp_ff;
      rp_in    = rp_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      scale_in = scale_ff;
      if (accept) begin
         wp_in    = wp_ff + 1'b1;
         rp_in    = rp_wide[PTR_W-1:0];
         phase_in = phase_next;
         scale_in = lfo_scale(phase_next);
         if (fill_ff != (PTR_W+1)'(RING_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      depth_in = depth_ff;
      step_in  = step_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEPTH:      depth_in = csr_wdata[DEPTH_W-1:0];
            CSR_PHASE_STEP: step_in  = csr_wdata[STEP_W-1:0];
            default:        ;
         endcase
      end

      s1_valid_in = s1_valid_ff;
      s1_hit_in   = s1_hit_ff;
      s1_fwd_in   = s1_fwd_ff;
      s1_left_in  = s1_left_ff;
      s1_right_in = s1_right_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_hit_in   = {1'b0, rp_ff} <= fill_ff;
         s1_fwd_in   = rp_ff == wp_ff;
         s1_left_in  = req_left_in;
         s1_right_in = req_right_in;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      priority if (!s1_hit_ff) begin
         sel_left  = '0;
         sel_right = '0;
      end else if (s1_fwd_ff) begin
         sel_left  = s1_left_ff;
         sel_right = s1_right_ff;
      end else begin
         sel_left  = ring_left;
         sel_right = ring_right;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = sel_left[SAMPLE_BITS-1:1];
         rsp_right_in = sel_right[SAMPLE_BITS-1:1];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         scale_ff     <= SCALE_ZERO;
         depth_ff     <= DEPTH_RESET;
         step_ff      <= STEP_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         scale_ff     <= scale_in;
         depth_ff     <= depth_in;
         step_ff      <= step_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hit_ff    <= s1_hit_in;
      s1_fwd_ff    <= s1_fwd_in;
      s1_left_ff   <= s1_left_in;
      s1_right_ff  <= s1_right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (PTR_W+1)'(RING_DEPTH))
      else $error("fill count exceeds ring depth");

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> wp_ff == PTR_W'($past(wp_ff) + 1'b1))
      else $error("write pointer did not advance on accept");

   a_s1_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat missing from read stage");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled while a stage was free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
